// ===== design/ssbc_pkg.sv =====
// Shared types, constants and rounding helpers for the sine saturation and clip stage.
`default_nettype none
package ssbc_pkg;

   localparam int SampleWidth   = 24;
   localparam int CoefWidth     = 32;
   localparam int StateWidth    = 40;
   localparam int WorkWidth     = 26;
   localparam int MulWidth      = 34;
   localparam int ProdWidth     = 64;
   localparam int ProductWidth  = 56;
   localparam int CsrIndexWidth = 3;
   localparam int CsrDataWidth  = 32;

   typedef logic signed [SampleWidth-1:0]  sample_type;
   typedef logic        [SampleWidth-1:0]  gain_type;
   typedef logic signed [CoefWidth-1:0]    coef_type;
   typedef logic signed [StateWidth-1:0]   fstate_type;
   typedef logic signed [WorkWidth-1:0]    work_type;
   typedef logic signed [MulWidth-1:0]     mul_type;
   typedef logic signed [ProdWidth-1:0]    wide_type;
   typedef logic signed [ProductWidth-1:0] product_type;
   typedef logic        [CsrIndexWidth-1:0] csr_index_type;
   typedef logic        [CsrDataWidth-1:0]  csr_data_type;
   typedef logic        [2:0]               step_type;

   localparam csr_index_type CSR_GAIN          = 3'd0;
   localparam csr_index_type CSR_FILTER_ENABLE = 3'd1;
   localparam csr_index_type CSR_COEF_A0       = 3'd2;
   localparam csr_index_type CSR_COEF_B1       = 3'd3;
   localparam csr_index_type CSR_COEF_B2       = 3'd4;

   localparam gain_type GAIN_RESET = 24'd4194304;

   localparam wide_type HALF_PI_Q22 = 64'sd6588397;
   localparam wide_type FOUR_Q22    = 64'sd16777216;
   localparam wide_type THRESH_Q22  = 64'sd4005529;
   localparam wide_type OFS_A_Q22   = 64'sd2960427;
   localparam wide_type OFS_B_Q22   = 64'sd1045102;
   localparam wide_type Y_MAX       = 64'sd33554431;
   localparam wide_type Y_MIN       = -64'sd33554432;
   localparam wide_type S40_MAX     = 64'sd549755813887;
   localparam wide_type S40_MIN     = -64'sd549755813888;
   localparam wide_type S24_MAX     = 64'sd8388607;
   localparam wide_type S24_MIN     = -64'sd8388608;

   localparam mul_type  MUL_A_Q30   = 34'sd280155133;
   localparam mul_type  MUL_B_Q30   = 34'sd793586583;
   localparam mul_type  POLY_INIT   = -34'sd27;
   localparam step_type POLY_LAST   = 3'd4;

   typedef enum logic [4:0] {
      S_IDLE,
      S_GIN_M, S_GIN_R,
      S_SQ_M, S_SQ_R,
      S_POLY_M, S_POLY_R,
      S_SINE_M, S_SINE_R,
      S_FA_M, S_FA_R,
      S_FB1_M, S_FB1_R,
      S_FB2_M, S_FB2_R,
      S_GOUT_M, S_GOUT_R,
      S_CP_M, S_CP_R,
      S_PT_M, S_PT_R,
      S_CN_M, S_CN_R,
      S_NT_M, S_NT_R
   } state_type;

   function automatic wide_type round_shift(input wide_type v, input int unsigned sh);
      wide_type half;
      half = 64'sd1 <<< (sh - 1);
      return (v + half) >>> sh;
   endfunction

   function automatic wide_type sat_wide(input wide_type v, input wide_type lo,
                                         input wide_type hi);
      wide_type r;
      r = v;
      if (v < lo) begin
         r = lo;
      end else if (v > hi) begin
         r = hi;
      end
      return r;
   endfunction

   function automatic wide_type poly_coef(input step_type step);
      wide_type c;
      case (step)
         3'd0:    c = 64'sd2959;
         3'd1:    c = -64'sd213044;
         3'd2:    c = 64'sd8947849;
         3'd3:    c = -64'sd178956971;
         default: c = 64'sd1073741824;
      endcase
      return c;
   endfunction

endpackage
`default_nettype wire

// ===== design/ssbc_if.sv =====
// Sample channel interfaces: request carries in_sample, response carries out_sample.
`default_nettype none
interface ssbc_req_if;
   logic                   valid;
   logic                   ready;
   ssbc_pkg::sample_type   in_sample;
   modport source (output valid, output in_sample, input ready);
   modport sink   (input valid, input in_sample, output ready);
endinterface

interface ssbc_rsp_if;
   logic                   valid;
   logic                   ready;
   ssbc_pkg::sample_type   out_sample;
   modport source (output valid, output out_sample, input ready);
   modport sink   (input valid, input out_sample, output ready);
endinterface
`default_nettype wire

// ===== design/sine_saturation_biquad_clip_stage_top.sv =====
// Sine saturation, optional biquad lowpass and memory soft-clipper on one shared multiplier.
// One sample at a time: req_chan.ready is high only while the block is idle. Every
// multiply goes through a single 34 x 34 bit signed multiplier, with one state to form
// the product and the next state to round, add and saturate it. Each sample runs the
// input gain, square, polynomial and sine steps, the biquad steps when the biquad is
// enabled, the output gain and the positive and negative threshold steps, plus a clip
// step for each of the positive and negative over flags set by the previous sample. The
// result sits in an output register; the next sample is taken while it waits, and a
// sample only stalls at its last step if the previous result is still untaken. The
// output is the clipper's held value, one sample behind the input.
`default_nettype none
module sine_saturation_biquad_clip_stage_top (
   input  wire logic                    clock,
   input  wire logic                    reset,
   ssbc_req_if.sink                     req_chan,
   ssbc_rsp_if.source                   rsp_chan,
   input  wire logic                    csr_we,
   input  wire ssbc_pkg::csr_index_type csr_index,
   input  wire ssbc_pkg::csr_data_type  csr_wdata
);
   import ssbc_pkg::*;

   state_type   state_ff, state_in;
   step_type    step_ff, step_in;
   sample_type  x_ff, x_in;
   sample_type  xs_ff, xs_in;
   mul_type     x2_ff, x2_in;
   mul_type     p_ff, p_in;
   work_type    y_ff, y_in;
   product_type sa_ff, sa_in;
   work_type    z_ff, z_in;
   work_type    held_ff, held_in;
   fstate_type  fs1_ff, fs1_in;
   fstate_type  fs2_ff, fs2_in;
   logic        pos_ff, pos_in;
   logic        neg_ff, neg_in;
   wide_type    prod_ff;
   logic        out_valid_ff, out_valid_in;
   sample_type  out_data_ff, out_data_in;

   gain_type    gain_ff;
   logic        fen_ff;
   coef_type    a0_ff, b1_ff, b2_ff;

   mul_type     mul_a, mul_b;
   logic        mul_en;
   logic signed [2*MulWidth-1:0] prod_full;
   mul_type     big_x;
   mul_type     gain_op;
   logic        z_lt, z_gt;
   wide_type    rnd30;
   wide_type    acc;
   wide_type    diff;
   wide_type    zf;

   assign big_x   = MulWidth'($signed({xs_ff, 8'd0}));
   assign gain_op = {{(MulWidth-SampleWidth){1'b0}}, gain_ff};
   assign z_lt    = z_ff < held_ff;
   assign z_gt    = z_ff > held_ff;
   assign rnd30   = round_shift(prod_ff, 30);

   assign req_chan.ready      = (state_ff == S_IDLE);
   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.out_sample = out_data_ff;

   // operand selection for the shared multiplier
   always_comb begin
      mul_en = 1'b1;
      mul_a  = '0;
      mul_b  = '0;
      unique case (state_ff)
         S_GIN_M: begin
            mul_a = MulWidth'(x_ff);
            mul_b = gain_op;
         end
         S_SQ_M: begin
            mul_a = big_x;
            mul_b = big_x;
         end
         S_POLY_M: begin
            mul_a = p_ff;
            mul_b = x2_ff;
         end
         S_SINE_M: begin
            mul_a = p_ff;
            mul_b = big_x;
         end
         S_FA_M: begin
            mul_a = MulWidth'(y_ff);
            mul_b = MulWidth'(a0_ff);
         end
         S_FB1_M: begin
            mul_a = MulWidth'(y_ff);
            mul_b = MulWidth'(b1_ff);
         end
         S_FB2_M: begin
            mul_a = MulWidth'(y_ff);
            mul_b = MulWidth'(b2_ff);
         end
         S_GOUT_M: begin
            mul_a = MulWidth'(y_ff);
            mul_b = gain_op;
         end
         S_CP_M: begin
            mul_a = z_lt ? MulWidth'(z_ff) : MulWidth'(held_ff);
            mul_b = z_lt ? MUL_A_Q30 : MUL_B_Q30;
         end
         S_CN_M: begin
            mul_a = z_gt ? MulWidth'(z_ff) : MulWidth'(held_ff);
            mul_b = z_gt ? MUL_A_Q30 : MUL_B_Q30;
         end
         S_PT_M, S_NT_M: begin
            mul_a = MulWidth'(held_ff);
            mul_b = MUL_A_Q30;
         end
         default: begin
            mul_en = 1'b0;
         end
      endcase
   end

   assign prod_full = (2*MulWidth)'(mul_a) * (2*MulWidth)'(mul_b);

   always_ff @(posedge clock) begin
      if (mul_en) begin
         prod_ff <= prod_full[ProdWidth-1:0];
      end
   end

   // sequencer: next state and write-back of each product
   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      x_in         = x_ff;
      xs_in        = xs_ff;
      x2_in        = x2_ff;
      p_in         = p_ff;
      y_in         = y_ff;
      sa_in        = sa_ff;
      z_in         = z_ff;
      held_in      = held_ff;
      fs1_in       = fs1_ff;
      fs2_in       = fs2_ff;
      pos_in       = pos_ff;
      neg_in       = neg_ff;
      out_valid_in = out_valid_ff && !rsp_chan.ready;
      out_data_in  = out_data_ff;
      acc          = '0;
      diff         = '0;
      zf           = ProdWidth'(z_ff);
      unique case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               x_in     = req_chan.in_sample;
               state_in = S_GIN_M;
            end
         end
         S_GIN_M: state_in = S_GIN_R;
         S_GIN_R: begin
            xs_in    = SampleWidth'(sat_wide(round_shift(prod_ff, 22), -HALF_PI_Q22,
                                             HALF_PI_Q22));
            state_in = S_SQ_M;
         end
         S_SQ_M: state_in = S_SQ_R;
         S_SQ_R: begin
            x2_in    = MulWidth'(rnd30);
            p_in     = POLY_INIT;
            step_in  = '0;
            state_in = S_POLY_M;
         end
         S_POLY_M: state_in = S_POLY_R;
         S_POLY_R: begin
            p_in     = MulWidth'(poly_coef(step_ff) + rnd30);
            step_in  = step_ff + 3'd1;
            state_in = (step_ff == POLY_LAST) ? S_SINE_M : S_POLY_M;
         end
         S_SINE_M: state_in = S_SINE_R;
         S_SINE_R: begin
            y_in     = WorkWidth'(round_shift(rnd30, 8));
            state_in = fen_ff ? S_FA_M : S_GOUT_M;
         end
         S_FA_M: state_in = S_FA_R;
         S_FA_R: begin
            sa_in    = ProductWidth'(prod_ff);
            acc      = round_shift(prod_ff, 22) + ProdWidth'(fs1_ff);
            y_in     = WorkWidth'(sat_wide(round_shift(acc, 7), Y_MIN, Y_MAX));
            state_in = S_FB1_M;
         end
         S_FB1_M: state_in = S_FB1_R;
         S_FB1_R: begin
            diff     = (ProdWidth'(sa_ff) <<< 1) - prod_ff;
            fs1_in   = StateWidth'(sat_wide(round_shift(diff, 22) + ProdWidth'(fs2_ff),
                                            S40_MIN, S40_MAX));
            state_in = S_FB2_M;
         end
         S_FB2_M: state_in = S_FB2_R;
         S_FB2_R: begin
            diff     = ProdWidth'(sa_ff) - prod_ff;
            fs2_in   = StateWidth'(sat_wide(round_shift(diff, 22), S40_MIN, S40_MAX));
            state_in = S_GOUT_M;
         end
         S_GOUT_M: state_in = S_GOUT_R;
         S_GOUT_R: begin
            z_in     = WorkWidth'(sat_wide(round_shift(prod_ff, 22), -FOUR_Q22, FOUR_Q22));
            state_in = pos_ff ? S_CP_M : S_PT_M;
         end
         S_CP_M: state_in = S_CP_R;
         S_CP_R: begin
            held_in  = WorkWidth'((z_lt ? OFS_A_Q22 : OFS_B_Q22) + rnd30);
            state_in = S_PT_M;
         end
         S_PT_M: state_in = S_PT_R;
         S_PT_R: begin
            pos_in = z_ff > THRESH_Q22;
            if (z_ff > THRESH_Q22) begin
               z_in = WorkWidth'(OFS_A_Q22 + rnd30);
            end
            state_in = neg_ff ? S_CN_M : S_NT_M;
         end
         S_CN_M: state_in = S_CN_R;
         S_CN_R: begin
            held_in  = WorkWidth'((z_gt ? -OFS_A_Q22 : -OFS_B_Q22) + rnd30);
            state_in = S_NT_M;
         end
         S_NT_M: state_in = S_NT_R;
         S_NT_R: begin
            // hold until the output register is free
            if (!out_valid_ff || rsp_chan.ready) begin
               neg_in = z_ff < -THRESH_Q22;
               if (z_ff < -THRESH_Q22) begin
                  zf = -OFS_A_Q22 + rnd30;
               end
               out_data_in  = SampleWidth'(sat_wide(ProdWidth'(held_ff), S24_MIN, S24_MAX));
               out_valid_in = 1'b1;
               held_in      = WorkWidth'(sat_wide(zf, S24_MIN, S24_MAX));
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= '0;
         held_ff      <= '0;
         fs1_ff       <= '0;
         fs2_ff       <= '0;
         pos_ff       <= 1'b0;
         neg_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         held_ff      <= held_in;
         fs1_ff       <= fs1_in;
         fs2_ff       <= fs2_in;
         pos_ff       <= pos_in;
         neg_ff       <= neg_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff        <= x_in;
      xs_ff       <= xs_in;
      x2_ff       <= x2_in;
      p_ff        <= p_in;
      y_ff        <= y_in;
      sa_ff       <= sa_in;
      z_ff        <= z_in;
      out_data_ff <= out_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff <= GAIN_RESET;
         fen_ff  <= 1'b0;
         a0_ff   <= '0;
         b1_ff   <= '0;
         b2_ff   <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_GAIN:          gain_ff <= csr_wdata[SampleWidth-1:0];
            CSR_FILTER_ENABLE: fen_ff  <= csr_wdata[0];
            CSR_COEF_A0:       a0_ff   <= csr_wdata;
            CSR_COEF_B1:       b1_ff   <= csr_wdata;
            CSR_COEF_B2:       b2_ff   <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> (state_ff == S_GIN_M))
      else $error("transfer did not start the sequence");

   a_fs1_only_in_update: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_FB1_R) |=> $stable(fs1_ff))
      else $error("biquad state one changed outside its update step");

   a_held_in_range_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> (held_ff <= work_type'(S24_MAX) &&
                                held_ff >= work_type'(S24_MIN)))
      else $error("held sample out of range between samples");

   a_stall_on_full_output: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_NT_R && out_valid_ff && !rsp_chan.ready) |=>
      (state_ff == S_NT_R && out_valid_ff && $stable(out_data_ff)))
      else $error("result overwritten before transfer");

endmodule
`default_nettype wire
